// ----- hw/rtl/keyed_user_zone_rule_table_defines.svh -----
// Assertion macros for the checker file.
`ifndef KEYED_USER_ZONE_RULE_TABLE_DEFINES_SVH
`define KEYED_USER_ZONE_RULE_TABLE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the next cycle.
`define KUZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Assert that an antecedent implies a consequent in the same cycle.
`define KUZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/kuzrt_pkg.sv -----
// ----------------------------------------------------------------------------
// kuzrt_pkg
// Types, codes and constants of the keyed user zone rule table.
// ----------------------------------------------------------------------------
`default_nettype none
package kuzrt_pkg;
  localparam int USERS_DEF     = 16;
  localparam int ZONES_DEF     = 32;
  localparam int RULE_BITS_DEF = 32;
  localparam int KEY_BITS      = 184;
  localparam int KEY_MAX       = 23;

  typedef enum logic [2:0] {
    REQ_ADD = 3'd0, REQ_REMOVE = 3'd1, REQ_SET = 3'd2, REQ_READ = 3'd3, REQ_POS = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_ZONE = 3'd1, ST_BAD_KEY = 3'd2, ST_NOT_FOUND = 3'd3,
    ST_FULL = 3'd4, ST_BAD_POS = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_CLEAR, S_SHIFT_RD, S_SHIFT_WR,
    S_RULE_RD, S_RULE_WAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  key_len;
    logic [63:0] key_lo;
    logic [63:0] key_mid;
    logic [55:0] key_hi;
    logic [15:0] zone;
    logic [31:0] rule_in;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] rule_out;
    logic [4:0]  key_len_out;
    logic [63:0] key_lo_out;
    logic [63:0] key_mid_out;
    logic [55:0] key_hi_out;
    logic [4:0]  entry_count;
  } out_item_t;

  // Keep the first len bytes of a 184-bit key.
  function automatic logic [KEY_BITS-1:0] trim_key(input logic [4:0] len,
                                                   input logic [KEY_BITS-1:0] k);
    logic [KEY_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_MAX; b++) begin
      if (b < int'(len)) m[b*8 +: 8] = 8'hFF;
    end
    return k & m;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/keyed_user_zone_rule_table.sv -----
// ----------------------------------------------------------------------------
// keyed_user_zone_rule_table
// Keyed table of users with one rule word per zone.
// ----------------------------------------------------------------------------
// Pulse start with an item on in_item while busy is low; busy rises the next
// cycle. Exactly one result appears on out_item with out_valid high for one
// cycle; the receiver cannot stall it. busy stays high through the cycle the
// result is shown and falls after it, so the next item can then be taken.
// A key search reads the stored keys from the key memory one user at a time,
// comparing each key read before the next is issued; a key that is not found
// is compared with every stored user. Add clears the user's ZONES rule words,
// one per cycle. Remove moves every later user down, key first and then its
// rule words one per cycle. Read rule adds a rule memory read and a wait
// state; set rule writes its word in the decision cycle, or during the
// clearing pass when the user is new.
// Reset empties the table at once; the memories need no clearing pass since
// data at positions at or above the user count is never returned.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_user_zone_rule_table #(
  parameter int USERS     = kuzrt_pkg::USERS_DEF,
  parameter int ZONES     = kuzrt_pkg::ZONES_DEF,
  parameter int RULE_BITS = kuzrt_pkg::RULE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire kuzrt_pkg::in_item_t  in_item,
  output logic                      out_valid,
  output kuzrt_pkg::out_item_t      out_item
);
  localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int CW = $clog2(USERS + 1);
  localparam int KW = kuzrt_pkg::KEY_BITS + 5;

  // Memories: key plus length, and rule words.
  logic [KW-1:0]        key_mem [USERS];
  logic [RULE_BITS-1:0] rule_mem [USERS*(2**ZW)];

  kuzrt_pkg::state_t state_r, state_nxt;
  kuzrt_pkg::in_item_t req_r;
  logic [kuzrt_pkg::KEY_BITS-1:0] key_r;
  logic          key_ok_r, zone_ok_r;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [ZW:0]   zc_r, zc_nxt;
  logic          found_r, found_nxt;
  logic [UW-1:0] pos_r, pos_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [KW-1:0] key_rd_r;
  logic [RULE_BITS-1:0] rule_rd_r, rule_hold_r;
  logic          out_valid_r;
  kuzrt_pkg::out_item_t out_r, out_nxt;

  // Memory port controls.
  logic          key_we, key_re;
  logic [UW-1:0] key_wa, key_ra;
  logic [KW-1:0] key_wd;
  logic          rule_we, rule_re;
  logic [UW+ZW-1:0] rule_wa, rule_ra;
  logic [RULE_BITS-1:0] rule_wd;
  logic          hold_rule;

  logic [ZW-1:0] zone_idx;
  logic          match;
  logic [CW:0]   pos_plus;

  assign zone_idx = ZW'(req_r.zone - 16'd1);
  assign match    = (key_rd_r[KW-1 -: 5] == req_r.key_len[4:0]) &&
                    (key_rd_r[kuzrt_pkg::KEY_BITS-1:0] == key_r);
  assign pos_plus = {1'b0, idx_r} + (CW+1)'(1);

  // Key memory.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (key_re) key_rd_r <= key_mem[key_ra];
  end

  // Rule memory.
  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[rule_wa] <= rule_wd;
    if (rule_re) rule_rd_r <= rule_mem[rule_ra];
  end

  // Capture the request and its derived checks.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r     <= in_item;
      key_ok_r  <= (in_item.key_len != 6'd0) && (in_item.key_len <= 6'(kuzrt_pkg::KEY_MAX));
      zone_ok_r <= (in_item.zone != 16'd0) && (32'(in_item.zone) <= 32'(ZONES));
      key_r     <= kuzrt_pkg::trim_key(in_item.key_len[4:0],
                     {in_item.key_hi, in_item.key_mid, in_item.key_lo});
    end
    if (hold_rule) rule_hold_r <= rule_rd_r;
    out_r <= out_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kuzrt_pkg::S_IDLE;
      total_r <= '0;
      idx_r <= '0; zc_r <= '0; found_r <= 1'b0; pos_r <= '0;
      status_r <= kuzrt_pkg::ST_OK; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      idx_r <= idx_nxt; zc_r <= zc_nxt; found_r <= found_nxt; pos_r <= pos_nxt;
      status_r <= status_nxt;
      out_valid_r <= (state_nxt == kuzrt_pkg::S_DONE);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kuzrt_pkg::S_IDLE: if (start) state_nxt = kuzrt_pkg::S_SCAN;
      kuzrt_pkg::S_SCAN: begin
        if (req_r.req_type == kuzrt_pkg::REQ_POS) state_nxt = kuzrt_pkg::S_SCAN_WAIT;
        else if (!key_ok_r || found_r || idx_r >= total_r) state_nxt = kuzrt_pkg::S_DECIDE;
        else state_nxt = kuzrt_pkg::S_SCAN_WAIT;
      end
      kuzrt_pkg::S_SCAN_WAIT:
        state_nxt = (req_r.req_type == kuzrt_pkg::REQ_POS) ? kuzrt_pkg::S_DONE
                                                          : kuzrt_pkg::S_SCAN;
      kuzrt_pkg::S_DECIDE: begin
        state_nxt = kuzrt_pkg::S_DONE;
        unique case (req_r.req_type) inside
          kuzrt_pkg::REQ_ADD, kuzrt_pkg::REQ_SET: begin
            if (req_r.req_type == kuzrt_pkg::REQ_SET && !zone_ok_r) state_nxt = kuzrt_pkg::S_DONE;
            else if (key_ok_r && !found_r && 32'(total_r) < 32'(USERS))
              state_nxt = kuzrt_pkg::S_CLEAR;
          end
          kuzrt_pkg::REQ_REMOVE:
            if (key_ok_r && found_r) state_nxt = kuzrt_pkg::S_SHIFT_RD;
          kuzrt_pkg::REQ_READ:
            if (zone_ok_r && key_ok_r && found_r) state_nxt = kuzrt_pkg::S_RULE_RD;
          default: state_nxt = kuzrt_pkg::S_DONE;
        endcase
      end
      kuzrt_pkg::S_CLEAR:
        if (32'(zc_r) == ZONES - 1) state_nxt = kuzrt_pkg::S_DONE;
      kuzrt_pkg::S_SHIFT_RD:
        state_nxt = (pos_plus >= (CW+1)'(total_r)) ? kuzrt_pkg::S_DONE
                                                   : kuzrt_pkg::S_SHIFT_WR;
      kuzrt_pkg::S_SHIFT_WR:
        if (32'(zc_r) == ZONES) state_nxt = kuzrt_pkg::S_SHIFT_RD;
      kuzrt_pkg::S_RULE_RD:   state_nxt = kuzrt_pkg::S_RULE_WAIT;
      kuzrt_pkg::S_RULE_WAIT: state_nxt = kuzrt_pkg::S_DONE;
      kuzrt_pkg::S_DONE:      state_nxt = kuzrt_pkg::S_IDLE;
      default:                state_nxt = kuzrt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls per state.
  always_comb begin
    total_nxt = total_r; idx_nxt = idx_r; zc_nxt = zc_r;
    found_nxt = found_r; pos_nxt = pos_r; status_nxt = status_r;
    key_we = 1'b0; key_re = 1'b0; key_wa = '0; key_ra = '0; key_wd = '0;
    rule_we = 1'b0; rule_re = 1'b0; rule_wa = '0; rule_ra = '0; rule_wd = '0;
    hold_rule = 1'b0;
    unique case (state_r)
      kuzrt_pkg::S_IDLE: begin
        idx_nxt = '0; zc_nxt = '0; found_nxt = 1'b0; status_nxt = kuzrt_pkg::ST_OK;
      end
      kuzrt_pkg::S_SCAN: begin
        // Issue one key read; on read user, read the requested position.
        if (req_r.req_type == kuzrt_pkg::REQ_POS) begin
          key_re = 1'b1;
          key_ra = UW'(req_r.position);
        end else if (key_ok_r && !found_r && idx_r < total_r) begin
          key_re = 1'b1;
          key_ra = UW'(idx_r);
        end
      end
      kuzrt_pkg::S_SCAN_WAIT: begin
        if (req_r.req_type != kuzrt_pkg::REQ_POS) begin
          if (match) begin
            found_nxt = 1'b1;
            pos_nxt = UW'(idx_r);
          end else idx_nxt = CW'(pos_plus);
        end
      end
      kuzrt_pkg::S_DECIDE: begin
        unique case (req_r.req_type) inside
          kuzrt_pkg::REQ_ADD, kuzrt_pkg::REQ_SET: begin
            if (req_r.req_type == kuzrt_pkg::REQ_SET && !zone_ok_r)
              status_nxt = kuzrt_pkg::ST_BAD_ZONE;
            else if (!key_ok_r) status_nxt = kuzrt_pkg::ST_BAD_KEY;
            else if (found_r) begin
              if (req_r.req_type == kuzrt_pkg::REQ_SET) begin
                rule_we = 1'b1;
                rule_wa = {pos_r, zone_idx};
                rule_wd = RULE_BITS'(req_r.rule_in);
              end
            end else if (32'(total_r) >= 32'(USERS)) status_nxt = kuzrt_pkg::ST_FULL;
            else begin
              // Append the key; rules are cleared in the next state.
              key_we = 1'b1;
              key_wa = UW'(total_r);
              key_wd = {req_r.key_len[4:0], key_r};
              pos_nxt = UW'(total_r);
              total_nxt = total_r + CW'(1);
            end
          end
          kuzrt_pkg::REQ_REMOVE: begin
            if (!key_ok_r || !found_r) status_nxt = kuzrt_pkg::ST_NOT_FOUND;
            else idx_nxt = CW'(pos_r);
          end
          kuzrt_pkg::REQ_READ: begin
            if (!zone_ok_r) status_nxt = kuzrt_pkg::ST_BAD_ZONE;
            else if (!key_ok_r || !found_r) status_nxt = kuzrt_pkg::ST_NOT_FOUND;
          end
          default: ;
        endcase
      end
      kuzrt_pkg::S_CLEAR: begin
        // Clear one rule word per cycle; a set writes its rule instead.
        rule_we = 1'b1;
        rule_wa = {pos_r, zc_r[ZW-1:0]};
        rule_wd = (req_r.req_type == kuzrt_pkg::REQ_SET && zc_r[ZW-1:0] == zone_idx)
                  ? RULE_BITS'(req_r.rule_in) : '0;
        zc_nxt = zc_r + (ZW+1)'(1);
      end
      kuzrt_pkg::S_SHIFT_RD: begin
        // Read the next user's key and first rule word.
        if (pos_plus >= (CW+1)'(total_r)) total_nxt = total_r - CW'(1);
        else begin
          key_re = 1'b1;
          key_ra = UW'(pos_plus);
          rule_re = 1'b1;
          rule_ra = {UW'(pos_plus), ZW'(0)};
          zc_nxt = '0;
        end
      end
      kuzrt_pkg::S_SHIFT_WR: begin
        // Move one word down per cycle, reading the word that follows it.
        if (zc_r == '0) begin
          key_we = 1'b1;
          key_wa = UW'(idx_r);
          key_wd = key_rd_r;
          hold_rule = 1'b1;
          zc_nxt = zc_r + (ZW+1)'(1);
        end else begin
          rule_we = 1'b1;
          rule_wa = {UW'(idx_r), ZW'(zc_r - (ZW+1)'(1))};
          rule_wd = (zc_r == (ZW+1)'(1)) ? rule_hold_r : rule_rd_r;
          if (32'(zc_r) < ZONES) begin
            rule_re = 1'b1;
            rule_ra = {UW'(pos_plus), ZW'(zc_r)};
          end
          if (32'(zc_r) == ZONES) idx_nxt = CW'(pos_plus);
          else zc_nxt = zc_r + (ZW+1)'(1);
        end
      end
      kuzrt_pkg::S_RULE_RD: begin
        rule_re = 1'b1;
        rule_ra = {pos_r, zone_idx};
      end
      kuzrt_pkg::S_RULE_WAIT: ;
      kuzrt_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // Build the result in the cycle before it is shown.
  always_comb begin
    out_nxt = '0;
    out_nxt.entry_count = 5'(total_nxt);
    out_nxt.status = status_nxt;
    if (state_r == kuzrt_pkg::S_RULE_WAIT)
      out_nxt.rule_out = 32'(rule_rd_r);
    if (state_r == kuzrt_pkg::S_SCAN_WAIT && req_r.req_type == kuzrt_pkg::REQ_POS) begin
      if (32'(req_r.position) >= 32'(total_r)) out_nxt.status = kuzrt_pkg::ST_BAD_POS;
      else begin
        out_nxt.key_len_out = key_rd_r[KW-1 -: 5];
        out_nxt.key_lo_out  = key_rd_r[63:0];
        out_nxt.key_mid_out = key_rd_r[127:64];
        out_nxt.key_hi_out  = key_rd_r[183:128];
      end
    end
    if (state_r == kuzrt_pkg::S_SCAN_WAIT && req_r.req_type > kuzrt_pkg::REQ_POS)
      out_nxt.status = kuzrt_pkg::ST_OK;
  end

  assign busy      = (state_r != kuzrt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

// ----- hw/rtl/kuzrt_checker.sv -----
// ----------------------------------------------------------------------------
// kuzrt_checker
// Port-level checks of the keyed user zone rule table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_user_zone_rule_table_defines.svh"
module kuzrt_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire kuzrt_pkg::out_item_t out_item
);
  // An accepted item makes the block busy.
  `KUZ_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  // A result is a single pulse.
  `KUZ_ASSERT_NEXT(a_single_pulse, clk, rst_n, out_valid, !out_valid)
  // The block is free after a result.
  `KUZ_ASSERT_NEXT(a_free_on_result, clk, rst_n, out_valid, !busy)
  // Count stays within the table and status codes are defined.
  `KUZ_ASSERT_NOW(a_fields, clk, rst_n, out_valid,
                  out_item.entry_count <= 5'd16 && out_item.status <= 3'd5)
endmodule

bind keyed_user_zone_rule_table kuzrt_checker u_kuzrt_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
